@@ design/iau_pkg.sv @@
// Interval ALU package: command codes, bound markers, shared helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iau_pkg;
    typedef enum logic [2:0] {
        CMD_JOIN = 3'd0,
        CMD_NEG  = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_DIV  = 3'd5
    } t_cmd;

    localparam logic signed [31:0] MINF = 32'sh8000_0000;
    localparam logic signed [31:0] PINF = 32'sh7FFF_FFFF;

    function automatic logic signed [31:0] negb(input logic signed [31:0] x);
        logic signed [31:0] r;
        if (x == MINF) r = PINF;
        else if (x == PINF) r = MINF;
        else r = -x;
        return r;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) r = PINF;
        else if (v < -64'sh0000_0000_8000_0000) r = MINF;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return (a > b) ? a : b;
    endfunction
endpackage
`default_nettype wire

@@ design/iau_div.sv @@
// Pipelined signed 32-bit divider, truncating toward zero, one quotient bit per stage.
// Depends on iau_pkg. Zero divisor gives zero, MINF / -1 gives PINF.
`timescale 1ns / 1ps
`default_nettype none
module iau_div (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire signed [31:0] i_num,
    input  wire signed [31:0] i_den,
    output logic signed [31:0] o_quo
);
    // stage 0 registers magnitudes; stages 1..32 one bit each; stage 33 sign fix
    logic [31:0] r_rem [0:32];
    logic [31:0] r_q   [0:32];
    logic [31:0] r_d   [0:32];
    logic        r_neg [0:32];
    logic        r_spec[0:32];
    logic [31:0] r_sv  [0:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num[31] ? 32'(-i_num) : i_num;
            r_d[0]    <= i_den[31] ? 32'(-i_den) : i_den;
            r_q[0]    <= '0;
            r_neg[0]  <= i_num[31] ^ i_den[31];
            r_spec[0] <= (i_den == 32'sd0) ||
                         (i_num == iau_pkg::MINF && i_den == -32'sd1);
            r_sv[0]   <= (i_den == 32'sd0) ? 32'd0 : iau_pkg::PINF;
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_step
        localparam int B = 31 - g;
        logic [63:0] n_sh;
        logic        n_ok;
        assign n_sh = {32'd0, r_d[g]} << B;
        assign n_ok = {32'd0, r_rem[g]} >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_ok ? 32'(r_rem[g] - n_sh[31:0]) : r_rem[g];
                r_q[g+1]    <= r_q[g] | (32'(n_ok) << B);
                r_d[g+1]    <= r_d[g];
                r_neg[g+1]  <= r_neg[g];
                r_spec[g+1] <= r_spec[g];
                r_sv[g+1]   <= r_sv[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= r_spec[32] ? r_sv[32] : (r_neg[32] ? 32'(-r_q[32]) : r_q[32]);
        end
    end
endmodule
`default_nettype wire

@@ design/iau_mul.sv @@
// Pipelined signed 32x32 multiplier with saturation to the infinity markers.
// Depends on iau_pkg. Its register depth matches the divider's.
`timescale 1ns / 1ps
`default_nettype none
module iau_mul (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire signed [31:0] i_a,
    input  wire signed [31:0] i_b,
    output logic signed [31:0] o_p
);
    localparam int DLY = 31;
    logic signed [31:0] r_a, r_b;
    logic signed [63:0] r_p;
    logic signed [31:0] r_d [0:DLY];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_p    <= 64'(r_a) * 64'(r_b);
            r_d[0] <= iau_pkg::sat64(r_p);
            for (int k = 1; k <= DLY; k++) r_d[k] <= r_d[k-1];
        end
    end
    assign o_p = r_d[DLY];
endmodule
`default_nettype wire

@@ design/interval_arithmetic_unit.sv @@
// Interval ALU top level: decode, pipelined multiply/divide lanes, output select.
// Depends on iau_pkg, iau_mul, iau_div.
//
// Usage: a word on the input channel (i_valid/o_ready) carries a command and two
// intervals A and B; one result word leaves on the output channel
// (o_valid/i_ready). Commands: join, negate A, add, subtract, multiply, divide.
// Bounds 0x80000000 and 0x7FFFFFFF mean minus and plus infinity.
// The divider lanes (operand register, 32 quotient-bit stages, sign fix) set the
// depth of the pipeline; the multiplier lanes are padded to the same depth.
// Throughput: one word per cycle while the receiver does not stall.
// The whole pipeline advances only when the output stage is free or being
// taken; when the receiver stalls every stage holds, so nothing is dropped or
// repeated, and o_ready stays high while the last stage can move.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module interval_arithmetic_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire        [2:0]  i_command,
    input  wire signed [31:0] i_a_low,
    input  wire signed [31:0] i_a_high,
    input  wire signed [31:0] i_b_low,
    input  wire signed [31:0] i_b_high,
    output logic              o_valid,
    input  wire               i_ready,
    output logic signed [31:0] o_res_low,
    output logic signed [31:0] o_res_high
);
    localparam int LAT = 34;  // lane latency: depth of the multiply and divide lanes

    typedef enum logic [1:0] {SEL_DIRECT, SEL_MUL, SEL_DIV} t_sel;

    logic adv;
    logic [LAT:0] r_vld;
    assign adv     = !r_vld[LAT] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-1:0], i_valid};
    end

    // ---- stage 1: decode, direct results, divider operand choice
    logic signed [31:0] al, ah, bl, bh, nbl, nbh, n_lo, n_hi, n_dn0, n_dd0, n_dn1, n_dd1;
    logic signed [31:0] n_bl2, n_bh2, m;
    logic n_mfull, n_dfull;
    logic [1:0] n_sel;
    logic lp, hp;
    assign al = i_a_low; assign ah = i_a_high; assign bl = i_b_low; assign bh = i_b_high;

    function automatic logic [63:0] f_neg(input logic signed [31:0] lo,
                                          input logic signed [31:0] hi);
        logic signed [31:0] rl, rh;
        if (lo == iau_pkg::MINF && hi == iau_pkg::PINF) begin rl = lo; rh = hi; end
        else if (lo == iau_pkg::PINF && hi == iau_pkg::MINF) begin rl = lo; rh = hi; end
        else if (lo == iau_pkg::MINF && hi == iau_pkg::MINF) begin
            rl = iau_pkg::PINF; rh = iau_pkg::PINF;
        end else if (lo == iau_pkg::PINF && hi == iau_pkg::PINF) begin
            rl = iau_pkg::MINF; rh = iau_pkg::MINF;
        end else if (hi == iau_pkg::PINF) begin
            rl = iau_pkg::MINF; rh = iau_pkg::negb(lo);
        end else if (lo == iau_pkg::MINF) begin
            rl = iau_pkg::negb(hi); rh = iau_pkg::PINF;
        end else begin
            rl = iau_pkg::smin(iau_pkg::negb(hi), iau_pkg::negb(lo));
            rh = iau_pkg::smax(iau_pkg::negb(hi), iau_pkg::negb(lo));
        end
        return {rl, rh};
    endfunction

    function automatic logic [63:0] f_add(input logic signed [31:0] xl,
        input logic signed [31:0] xh, input logic signed [31:0] yl,
        input logic signed [31:0] yh);
        logic signed [31:0] rl, rh;
        if (xl == iau_pkg::PINF || yl == iau_pkg::PINF) rl = iau_pkg::PINF;
        else if (xl == iau_pkg::MINF || yl == iau_pkg::MINF) rl = iau_pkg::MINF;
        else rl = iau_pkg::sat64(64'(xl) + 64'(yl));
        if (xh == iau_pkg::MINF || yh == iau_pkg::MINF) rh = iau_pkg::MINF;
        else if (xh == iau_pkg::PINF || yh == iau_pkg::PINF) rh = iau_pkg::PINF;
        else rh = iau_pkg::sat64(64'(xh) + 64'(yh));
        return {rl, rh};
    endfunction

    assign {nbl, nbh} = f_neg(bl, bh);
    assign n_mfull = (al == iau_pkg::MINF && ah == iau_pkg::PINF) ||
                     (al == iau_pkg::PINF && ah == iau_pkg::MINF) ||
                     (bl == iau_pkg::MINF && bh == iau_pkg::PINF) ||
                     (bl == iau_pkg::PINF && bh == iau_pkg::MINF);
    assign lp = al > 0;
    assign hp = ah > 0;
    assign n_bl2 = (bl == 0) ? 32'sd1 : bl;
    assign n_bh2 = (bh == 0) ? -32'sd1 : bh;
    assign m = iau_pkg::smax((al == iau_pkg::MINF) ? iau_pkg::PINF : (al < 0 ? -al : al),
                             (ah == iau_pkg::MINF) ? iau_pkg::PINF : (ah < 0 ? -ah : ah));

    always_comb begin
        n_lo = iau_pkg::MINF; n_hi = iau_pkg::PINF; n_sel = SEL_DIRECT;
        n_dn0 = al; n_dd0 = n_bl2; n_dn1 = ah; n_dd1 = n_bl2; n_dfull = 1'b0;
        unique case (i_command)
            iau_pkg::CMD_JOIN: begin
                if (al == iau_pkg::MINF && ah == iau_pkg::PINF) ;
                else if (al == iau_pkg::PINF && ah == iau_pkg::MINF) begin
                    n_lo = bl; n_hi = bh;
                end else if (al == iau_pkg::MINF && bh == iau_pkg::PINF) ;
                else if (al == iau_pkg::MINF) n_hi = iau_pkg::smax(ah, bh);
                else if (ah == iau_pkg::PINF) n_lo = iau_pkg::smin(al, bl);
                else begin
                    n_lo = iau_pkg::smin(al, bl); n_hi = iau_pkg::smax(ah, bh);
                end
            end
            iau_pkg::CMD_NEG: {n_lo, n_hi} = f_neg(al, ah);
            iau_pkg::CMD_ADD: {n_lo, n_hi} = f_add(al, ah, bl, bh);
            iau_pkg::CMD_SUB: {n_lo, n_hi} = f_add(al, ah, nbl, nbh);
            iau_pkg::CMD_MUL: n_sel = n_mfull ? SEL_DIRECT : SEL_MUL;
            iau_pkg::CMD_DIV: begin
                if (n_mfull) ;
                else if (bl < 0 && bh > 0) begin
                    n_lo = iau_pkg::negb(m); n_hi = m;
                end else if (bl == 0 && bh == 0) ;
                else begin
                    n_sel = SEL_DIV;
                    if (n_bl2 >= 0) begin
                        if (lp && hp) begin n_dd0 = n_bh2; n_dd1 = n_bl2; end
                        else if (!lp && !hp) begin n_dd0 = n_bl2; n_dd1 = n_bh2; end
                        else if (!lp && hp) begin n_dd0 = n_bl2; n_dd1 = n_bl2; end
                        else n_dfull = 1'b1;
                    end else if (n_bh2 <= 0) begin
                        n_dn0 = ah; n_dn1 = al;
                        if (lp && hp) begin n_dd0 = n_bh2; n_dd1 = n_bl2; end
                        else if (!lp && !hp) begin n_dd0 = n_bl2; n_dd1 = n_bh2; end
                        else if (!lp && hp) begin n_dd0 = n_bh2; n_dd1 = n_bh2; end
                        else n_dfull = 1'b1;
                    end else n_dfull = 1'b1;
                    if (n_dfull) n_sel = SEL_DIRECT;
                end
            end
            default: ;
        endcase
    end

    // ---- lanes: direct result delayed, four products, two quotients
    logic signed [31:0] r_dlo [0:LAT-1];
    logic signed [31:0] r_dhi [0:LAT-1];
    logic [1:0]         r_sel [0:LAT-1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dlo[0] <= n_lo; r_dhi[0] <= n_hi; r_sel[0] <= n_sel;
            for (int k = 1; k < LAT; k++) begin
                r_dlo[k] <= r_dlo[k-1]; r_dhi[k] <= r_dhi[k-1]; r_sel[k] <= r_sel[k-1];
            end
        end
    end

    logic signed [31:0] p0, p1, p2, p3, q0, q1;
    iau_mul u_m0 (.i_clk, .i_en(adv), .i_a(al), .i_b(bl), .o_p(p0));
    iau_mul u_m1 (.i_clk, .i_en(adv), .i_a(ah), .i_b(bl), .o_p(p1));
    iau_mul u_m2 (.i_clk, .i_en(adv), .i_a(al), .i_b(bh), .o_p(p2));
    iau_mul u_m3 (.i_clk, .i_en(adv), .i_a(ah), .i_b(bh), .o_p(p3));
    iau_div u_d0 (.i_clk, .i_en(adv), .i_num(n_dn0), .i_den(n_dd0), .o_quo(q0));
    iau_div u_d1 (.i_clk, .i_en(adv), .i_num(n_dn1), .i_den(n_dd1), .o_quo(q1));

    // ---- output stage: select and reduce products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            unique case (r_sel[LAT-1])
                SEL_MUL: begin
                    o_res_low  <= iau_pkg::smin(iau_pkg::smin(p0, p1), iau_pkg::smin(p2, p3));
                    o_res_high <= iau_pkg::smax(iau_pkg::smax(p0, p1), iau_pkg::smax(p2, p3));
                end
                SEL_DIV: begin o_res_low <= q0; o_res_high <= q1; end
                default: begin o_res_low <= r_dlo[LAT-1]; o_res_high <= r_dhi[LAT-1]; end
            endcase
        end
    end

    // hold the result while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_low) && $stable(o_res_high))
        else $error("result changed under stall");
    // the input side stalls only when a result word waits on a stalled receiver
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output stall");
endmodule
`default_nettype wire
